// ----- src/asstr_pkg.sv -----
// Package for the alignment score stripe: sizes, register indexes and the
// token that moves down the cell chain. No dependencies.
package asstr_pkg;

    localparam int ROWS    = 64;
    localparam int SCORE_W = 32;
    localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_W   = $clog2(ROWS + 1);
    localparam int SYM_W   = 8;
    localparam int PEN_W   = 8;
    localparam int RIU_W   = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [PEN_W-1:0] MATCH_RESET    = PEN_W'(2);
    localparam logic [PEN_W-1:0] MISMATCH_RESET = PEN_W'(1);
    localparam logic [RIU_W-1:0] ROWS_IN_USE_RESET = RIU_W'(64);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_SCORE      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH_PENALTY = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE      = CFG_IDX_W'(2);

    // item as it travels down the chain, one cell per cycle unless the chain is stalled
    typedef struct packed {
        logic                      valid;
        logic                      col;     // column item (else load)
        logic                      wr;      // load writes a query symbol
        logic [ROW_W-1:0]          target;  // row a load writes
        logic [SYM_W-1:0]          symbol;
        logic                      restart;
        logic signed [SCORE_W-1:0] north;   // new score of the row above
        logic signed [SCORE_W-1:0] nw;      // old score of the row above
        logic                      ovf;
    } token_t;

endpackage

// ----- src/asstr_cell.sv -----
// One stripe row: holds its query symbol and west score, updates the score
// for a passing column item and registers the item toward the next row.
// Depends on asstr_pkg.
module asstr_cell
    import asstr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [ROW_W-1:0] idx,
    input  logic             active,
    input  logic [PEN_W-1:0] match_score,
    input  logic [PEN_W-1:0] mismatch_penalty,
    input  token_t           tok_in,
    output token_t           tok_out
);

    logic [SYM_W-1:0]          q_reg;
    logic signed [SCORE_W-1:0] west_reg;
    logic signed [SCORE_W-1:0] west_next;
    token_t                    tok_reg;
    token_t                    tok_next;

    logic signed [SCORE_W-1:0] w;
    logic signed [SCORE_W-1:0] m;
    logic signed [PEN_W:0]     bonus;
    logic signed [SCORE_W:0]   sum;
    logic signed [SCORE_W-1:0] sat;
    logic                      sat_ovf;
    logic                      upd;

    always_comb
    begin
        w = tok_in.restart ? '0 : west_reg;
        m = (tok_in.nw > tok_in.north) ? tok_in.nw : tok_in.north;
        if (w > m)
        begin
            m = w;
        end
        if (q_reg == tok_in.symbol)
        begin
            bonus = $signed({1'b0, match_score});
        end
        else
        begin
            bonus = -$signed({1'b0, mismatch_penalty});
        end
        sum = {m[SCORE_W-1], m} + {{(SCORE_W-PEN_W){bonus[PEN_W]}}, bonus};
        // sign and top bit disagree: clamp toward the sign
        sat_ovf = sum[SCORE_W] ^ sum[SCORE_W-1];
        if (sat_ovf)
        begin
            sat = sum[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}}
                               : {1'b0, {(SCORE_W-1){1'b1}}};
        end
        else
        begin
            sat = sum[SCORE_W-1:0];
        end

        upd       = tok_in.valid && tok_in.col && active;
        tok_next  = tok_in;
        west_next = west_reg;
        if (upd)
        begin
            tok_next.north = sat;
            tok_next.nw    = w;
            tok_next.ovf   = tok_in.ovf | sat_ovf;
            west_next      = sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg  <= '0;
            west_reg <= '0;
        end
        else if (en)
        begin
            tok_reg  <= tok_next;
            west_reg <= west_next;
        end
    end

    // query symbol, no reset
    always_ff @(posedge clk)
    begin
        if (en && tok_in.valid && !tok_in.col && tok_in.wr && tok_in.target == idx)
        begin
            q_reg <= tok_in.symbol;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ----- src/alignment_score_stripe_top.sv -----
// Top level of the alignment score stripe: entry logic, configuration
// registers, the chain of row cells and the output register.
// Depends on asstr_pkg and asstr_cell.

// The stripe is a chain of ROWS cells, one per query row, each holding its
// query symbol and its west score. Every accepted item (load or column)
// enters row 0 and moves down one row per cycle while the chain is not
// frozen, so a new item can be taken every cycle unless the result side
// stalls. A column's bottom score passes through the register of every
// cell and then the output register; the chain length sets that delay
// regardless of rows_in_use. Rows at or beyond rows_in_use let
// a column pass unchanged, so the last cell always carries the bottom score
// of the last used row. Load items travel the same chain and write their
// row's symbol when they reach it, so loads and columns stay in order. Any
// stall on the result side freezes the whole chain. Reading a query symbol
// that was never loaded gives an undefined score. Configuration writes are
// taken at any time (cfg_ready is always high) but must only be issued
// while no item is in flight.
module alignment_score_stripe_top
    import asstr_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [PEN_W-1:0]          cfg_data,
    // input items
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      func,
    input  logic [SYM_W-1:0]          symbol,
    input  logic signed [SCORE_W-1:0] north_score,
    input  logic                      restart,
    // result items
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [SCORE_W-1:0] bottom_score,
    output logic                      overflow
);

    logic [PEN_W-1:0] match_reg;
    logic [PEN_W-1:0] mismatch_reg;
    logic [RIU_W-1:0] rows_in_use_reg;

    logic [CNT_W-1:0]          load_row_reg;
    logic [CNT_W-1:0]          load_row_next;
    logic signed [SCORE_W-1:0] prev_north_reg;

    logic                      out_valid_reg;
    logic signed [SCORE_W-1:0] bottom_reg;
    logic                      ovf_reg;

    logic             en;
    logic             accept;
    logic [ROW_W-1:0] tap;
    logic [ROWS-1:0]  active;
    token_t           entry;
    token_t           chain [ROWS+1];

    // whole chain advances unless a finished result is still waiting
    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;
    assign accept    = in_valid && en;
    assign cfg_ready = 1'b1;

    // last used row: zero acts as one, above ROWS acts as ROWS
    always_comb
    begin
        if (rows_in_use_reg == '0)
        begin
            tap = '0;
        end
        else if (32'(rows_in_use_reg) > ROWS)
        begin
            tap = ROW_W'(ROWS - 1);
        end
        else
        begin
            tap = ROW_W'(rows_in_use_reg - RIU_W'(1));
        end
    end

    // entry token and load row pointer
    always_comb
    begin
        load_row_next = load_row_reg;
        entry.valid   = accept;
        entry.col     = func;
        entry.wr      = 1'b0;
        entry.target  = load_row_reg[ROW_W-1:0];
        entry.symbol  = symbol;
        entry.restart = restart;
        entry.north   = north_score;
        entry.nw      = restart ? '0 : prev_north_reg;
        entry.ovf     = 1'b0;
        if (!func)
        begin
            if (restart)
            begin
                entry.wr      = 1'b1;
                entry.target  = '0;
                load_row_next = CNT_W'(1);
            end
            else if (32'(load_row_reg) < ROWS)
            begin
                entry.wr      = 1'b1;
                load_row_next = load_row_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg       <= MATCH_RESET;
            mismatch_reg    <= MISMATCH_RESET;
            rows_in_use_reg <= ROWS_IN_USE_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MATCH_SCORE:      match_reg       <= cfg_data;
                CFG_MISMATCH_PENALTY: mismatch_reg    <= cfg_data;
                CFG_ROWS_IN_USE:      rows_in_use_reg <= cfg_data[RIU_W-1:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_row_reg   <= '0;
            prev_north_reg <= '0;
        end
        else if (accept)
        begin
            load_row_reg <= load_row_next;
            if (func)
            begin
                prev_north_reg <= north_score;
            end
        end
    end

    assign chain[0] = entry;

    genvar gi;
    generate
        for (gi = 0; gi < ROWS; gi++)
        begin : g_row
            assign active[gi] = (ROW_W'(gi) <= tap);

            asstr_cell u_cell (
                .clk              (clk),
                .rst_n            (rst_n),
                .en               (en),
                .idx              (ROW_W'(gi)),
                .active           (active[gi]),
                .match_score      (match_reg),
                .mismatch_penalty (mismatch_reg),
                .tok_in           (chain[gi]),
                .tok_out          (chain[gi+1])
            );
        end
    endgenerate

    // output register: captures a column item leaving the last cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= chain[ROWS].valid && chain[ROWS].col;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bottom_reg <= chain[ROWS].north;
            ovf_reg    <= chain[ROWS].ovf;
        end
    end

    assign out_valid    = out_valid_reg;
    assign bottom_score = bottom_reg;
    assign overflow     = ovf_reg;

    // load pointer never runs past the stripe
    a_load_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(load_row_reg) <= ROWS)
        else $error("load row pointer past stripe");

    // a column item leaving the chain always becomes a result
    a_col_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        en && chain[ROWS].valid && chain[ROWS].col |=> out_valid_reg)
        else $error("column item lost at chain end");

    // a load item leaving the chain never becomes a result
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        en && !(chain[ROWS].valid && chain[ROWS].col) |=> !out_valid_reg)
        else $error("result without a column item");

    // a waiting result holds while the chain is frozen
    a_hold_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(bottom_reg) && $stable(chain[ROWS].valid))
        else $error("chain moved while stalled");

endmodule
